// ===== rtl/cau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and the saturation helper of the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DIV  = 3'd3,
		KIND_NEG  = 3'd4,
		KIND_ID   = 3'd5,
		KIND_MAG  = 3'd6,
		KIND_CONJ = 3'd7
	} kind_t;

	localparam int unsigned DEFAULT_FRAC_BITS = 16;

	// queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;

	// quotient bits developed by the divider, square root steps
	localparam int unsigned QUO_W      = 33;
	localparam int unsigned SQRT_STEPS = 32;

	// classified item handed from front to back
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
		logic signed [31:0] sq_x;
		logic signed [31:0] sq_y;
	} cau_item_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} sat_res_t;

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	function automatic sat_res_t sat32(input logic signed [65:0] v);
		sat_res_t r;
		r.val = v[31:0];
		r.sat = 1'b0;
		if (v > SAT_MAX) begin
			r.val = 32'sh7FFF_FFFF;
			r.sat = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = 32'sh8000_0000;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Accepts input transactions, decodes the operation and picks the operands
// of the squaring multipliers, then hands the item to the queue.
// ----------------------------------------------------------------------------
module cau_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [127:0]      s_tdata,  // a_re, a_im, b_re, b_im
	input  wire logic [2:0]        s_tuser,  // kind
	output logic                   q_valid,
	input  wire logic              q_ready,
	output cau_pkg::cau_item_t     q_item
);
	import cau_pkg::*;

	logic      vld_s1;
	cau_item_t item_s1;
	cau_item_t item_d;

	always_comb begin
		item_d.kind = kind_t'(s_tuser);
		item_d.a_re = s_tdata[31:0];
		item_d.a_im = s_tdata[63:32];
		item_d.b_re = s_tdata[95:64];
		item_d.b_im = s_tdata[127:96];
		// magnitude squares the first operand, divide squares the second
		if (item_d.kind == KIND_MAG) begin
			item_d.sq_x = item_d.a_re;
			item_d.sq_y = item_d.a_im;
		end else begin
			item_d.sq_x = item_d.b_re;
			item_d.sq_y = item_d.b_im;
		end
	end

	assign s_tready = !vld_s1 || q_ready;
	assign q_valid  = vld_s1;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cau_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module cau_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire cau_pkg::cau_item_t push_item,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output cau_pkg::cau_item_t     pop_item
);
	import cau_pkg::*;

	cau_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != (QPTR_W + 1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cau_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, setup, one restoring divide step per
// stage (root step in all but the last), then result select, output register.
// ----------------------------------------------------------------------------
module cau_back #(
	parameter int unsigned FRAC_BITS = cau_pkg::DEFAULT_FRAC_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cau_pkg::cau_item_t in_item,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,  // res_re, res_im
	output logic [1:0]             m_tuser   // zero_divide, saturated
);
	import cau_pkg::*;

	localparam int unsigned NW = 64 + FRAC_BITS;

	typedef struct packed {
		logic              neg;
		logic              ovf;
		logic [63:0]       rem;
		logic [QUO_W-1:0]  low;
		logic [QUO_W-1:0]  quo;
	} lane_t;

	typedef struct packed {
		logic               vld;
		kind_t              kind;
		logic signed [31:0] e_re;
		logic signed [31:0] e_im;
		logic               e_sat;
		logic               zdiv;
		logic [63:0]        d;
		lane_t [1:0]        lane;
		logic [63:0]        sq_s;
		logic [63:0]        sq_res;
	} iter_t;

	logic en;

	// stage 1: products and simple operations
	logic               vld_s1;
	kind_t              kind_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [31:0] simp_re_s1, simp_im_s1;
	logic               simp_sat_s1;
	sat_res_t           sr_re, sr_im;

	// stage 2: sums
	logic               vld_s2;
	kind_t              kind_s2;
	logic signed [31:0] simp_re_s2, simp_im_s2;
	logic               simp_sat_s2;
	logic signed [65:0] mre_s2, mim_s2, nre_s2, nim_s2;
	logic [63:0]        d_s2;

	iter_t itr_s [QUO_W+1];
	iter_t setup;

	assign en       = !m_tvalid || m_tready;
	assign in_ready = en;

	always_comb begin
		sr_re = '0;
		sr_im = '0;
		unique case (in_item.kind)
			KIND_ADD: begin
				sr_re = sat32(66'(in_item.a_re) + 66'(in_item.b_re));
				sr_im = sat32(66'(in_item.a_im) + 66'(in_item.b_im));
			end
			KIND_SUB: begin
				sr_re = sat32(66'(in_item.a_re) - 66'(in_item.b_re));
				sr_im = sat32(66'(in_item.a_im) - 66'(in_item.b_im));
			end
			KIND_NEG: begin
				sr_re = sat32(-66'(in_item.a_re));
				sr_im = sat32(-66'(in_item.a_im));
			end
			KIND_ID: begin
				sr_re.val = in_item.a_re;
				sr_im.val = in_item.a_im;
			end
			KIND_CONJ: begin
				sr_re.val = in_item.a_re;
				sr_im = sat32(-66'(in_item.a_im));
			end
			KIND_MUL, KIND_DIV, KIND_MAG: begin
				sr_re = '0;
				sr_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1     <= in_item.kind;
			p0_s1       <= in_item.a_re * in_item.b_re;
			p1_s1       <= in_item.a_im * in_item.b_im;
			p2_s1       <= in_item.a_re * in_item.b_im;
			p3_s1       <= in_item.a_im * in_item.b_re;
			p4_s1       <= in_item.sq_x * in_item.sq_x;
			p5_s1       <= in_item.sq_y * in_item.sq_y;
			simp_re_s1  <= sr_re.val;
			simp_im_s1  <= sr_im.val;
			simp_sat_s1 <= sr_re.sat | sr_im.sat;

			kind_s2     <= kind_s1;
			simp_re_s2  <= simp_re_s1;
			simp_im_s2  <= simp_im_s1;
			simp_sat_s2 <= simp_sat_s1;
			mre_s2      <= 66'(p0_s1) - 66'(p1_s1);
			mim_s2      <= 66'(p2_s1) + 66'(p3_s1);
			nre_s2      <= 66'(p0_s1) + 66'(p1_s1);
			nim_s2      <= 66'(p3_s1) - 66'(p2_s1);
			d_s2        <= 64'($unsigned(p4_s1)) + 64'($unsigned(p5_s1));
		end
	end

	// setup: multiply results, divider start, square root start
	always_comb begin
		logic signed [65:0] mul_re, mul_im;
		logic signed [65:0] num [2];
		logic [63:0]        mag;
		logic [NW-1:0]      nx;
		sat_res_t           rm_re, rm_im;
		mul_re = mre_s2 >>> FRAC_BITS;
		mul_im = mim_s2 >>> FRAC_BITS;
		rm_re  = sat32(mul_re);
		rm_im  = sat32(mul_im);
		num[0] = nre_s2;
		num[1] = nim_s2;

		setup.vld  = vld_s2;
		setup.kind = kind_s2;
		if (kind_s2 == KIND_MUL) begin
			setup.e_re  = rm_re.val;
			setup.e_im  = rm_im.val;
			setup.e_sat = rm_re.sat | rm_im.sat;
		end else begin
			setup.e_re  = simp_re_s2;
			setup.e_im  = simp_im_s2;
			setup.e_sat = simp_sat_s2;
		end
		setup.zdiv = d_s2 == '0;
		setup.d    = d_s2;
		for (int l = 0; l < 2; l++) begin
			setup.lane[l].neg = num[l] < 0;
			mag = setup.lane[l].neg ? 64'(-num[l]) : 64'(num[l]);
			nx  = {mag, {FRAC_BITS{1'b0}}};
			setup.lane[l].rem = 64'(nx[NW-1:QUO_W]);
			// quotient would not fit the developed bits
			setup.lane[l].ovf = setup.lane[l].rem >= d_s2;
			setup.lane[l].low = nx[QUO_W-1:0];
			setup.lane[l].quo = '0;
		end
		setup.sq_s   = d_s2;
		setup.sq_res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itr_s[0] <= '0;
		end else if (en) begin
			itr_s[0] <= setup;
		end
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic [63:0] sq_s_n;
		logic [63:0] sq_res_n;
		iter_t       nxt;

		if (i < SQRT_STEPS) begin : g_sq
			localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * i);
			always_comb begin
				if (itr_s[i].sq_s >= itr_s[i].sq_res + SQ_BIT) begin
					sq_s_n   = itr_s[i].sq_s - (itr_s[i].sq_res + SQ_BIT);
					sq_res_n = (itr_s[i].sq_res >> 1) + SQ_BIT;
				end else begin
					sq_s_n   = itr_s[i].sq_s;
					sq_res_n = itr_s[i].sq_res >> 1;
				end
			end
		end else begin : g_sq_hold
			assign sq_s_n   = itr_s[i].sq_s;
			assign sq_res_n = itr_s[i].sq_res;
		end

		always_comb begin
			logic [64:0] r;
			nxt        = itr_s[i];
			nxt.sq_s   = sq_s_n;
			nxt.sq_res = sq_res_n;
			for (int l = 0; l < 2; l++) begin
				r = {itr_s[i].lane[l].rem, itr_s[i].lane[l].low[QUO_W-1]};
				nxt.lane[l].low = itr_s[i].lane[l].low << 1;
				if (r >= {1'b0, itr_s[i].d}) begin
					nxt.lane[l].rem = 64'(r - {1'b0, itr_s[i].d});
					nxt.lane[l].quo = {itr_s[i].lane[l].quo[QUO_W-2:0], 1'b1};
				end else begin
					nxt.lane[l].rem = r[63:0];
					nxt.lane[l].quo = {itr_s[i].lane[l].quo[QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				itr_s[i+1] <= '0;
			end else if (en) begin
				itr_s[i+1] <= nxt;
			end
		end
	end

	// result select
	iter_t              last;
	sat_res_t           dv [2];
	sat_res_t           sq;
	logic signed [31:0] o_re, o_im;
	logic               o_zd, o_sat;

	assign last = itr_s[QUO_W];

	always_comb begin
		logic [QUO_W:0]     qm;
		logic signed [65:0] qe;
		for (int l = 0; l < 2; l++) begin
			if (last.lane[l].ovf) begin
				qm = (QUO_W + 1)'(33'h0_FFFF_FFFF);
			end else begin
				// round toward minus infinity on a negative quotient
				qm = {1'b0, last.lane[l].quo}
					+ (QUO_W + 1)'(last.lane[l].neg && (last.lane[l].rem != '0));
			end
			qe    = 66'(qm);
			dv[l] = sat32(last.lane[l].neg ? -qe : qe);
		end
		sq = sat32(66'(last.sq_res));

		o_zd = 1'b0;
		unique case (last.kind)
			KIND_DIV: begin
				if (last.zdiv) begin
					o_re  = '0;
					o_im  = '0;
					o_sat = 1'b0;
					o_zd  = 1'b1;
				end else begin
					o_re  = dv[0].val;
					o_im  = dv[1].val;
					o_sat = dv[0].sat | dv[1].sat;
				end
			end
			KIND_MAG: begin
				o_re  = sq.val;
				o_im  = '0;
				o_sat = sq.sat;
			end
			KIND_ADD, KIND_SUB, KIND_MUL, KIND_NEG, KIND_ID, KIND_CONJ: begin
				o_re  = last.e_re;
				o_im  = last.e_im;
				o_sat = last.e_sat;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {o_im, o_re};
			m_tuser <= {o_sat, o_zd};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, sub, mul, div, neg, identity, magnitude and conjugate in
// signed fixed point with saturation and a zero-denominator flag.
//
// channel  dir  tdata                         tuser
// s_       in   a_re, a_im, b_re, b_im (128)  kind (3)
// m_       out  res_re, res_im (64)           zero_divide, saturated (2)
//
// One transaction per cycle sustained while m_tready is high. The path is
// front register, queue, three setup stages, 33 divide steps (one quotient
// bit per stage, plus one root bit per stage in all but the last), output
// register. arst_n clears all valid bits; the back pipeline holds while
// m_tready is low and the four-entry queue absorbs the front until it fills.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int unsigned FRAC_BITS = cau_pkg::DEFAULT_FRAC_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // a_re, a_im, b_re, b_im
	input  wire logic [2:0]   s_tuser,  // kind
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,  // res_re, res_im
	output logic [1:0]        m_tuser   // zero_divide, saturated
);
	import cau_pkg::*;

	logic      f_valid, f_ready;
	cau_item_t f_item;
	logic      b_valid, b_ready;
	cau_item_t b_item;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_item   (f_item)
	);

	cau_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	cau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (b_valid),
		.in_ready (b_ready),
		.in_item  (b_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== tb/complex_arithmetic_unit_checker.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_checker
// Watches both stream channels of the complex ALU. It predicts every result
// from the accepted operands and compares each output transaction field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_checker #(
	parameter int unsigned FRAC_BITS = cau_pkg::DEFAULT_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,  // a_re, a_im, b_re, b_im
	input  logic [2:0]   s_tuser,  // kind
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,  // res_re, res_im
	input  logic [1:0]   m_tuser,  // zero_divide, saturated
	output int           mismatches,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import cau_pkg::*;

	typedef struct packed {
		logic [31:0] res_re;
		logic [31:0] res_im;
		logic        zero_divide;
		logic        saturated;
	} cplx_result_t;

	cplx_result_t result_q[$];

	function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// floor of n * 2^FRAC_BITS / d with d > 0
	function automatic logic signed [127:0] floor_div(input logic signed [127:0] n,
			input logic signed [127:0] d);
		logic signed [127:0] num, q;
		num = n <<< FRAC_BITS;
		q = num / d;
		if (num < 0 && (num % d) != 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] s);
		logic [63:0] res, bw;
		res = '0;
		bw = 64'd1 << 62;
		while (bw > s)
			bw = bw >> 2;
		while (bw != 0) begin
			if (s >= res + bw) begin
				s = s - (res + bw);
				res = (res >> 1) + bw;
			end else begin
				res = res >> 1;
			end
			bw = bw >> 2;
		end
		return res;
	endfunction

	function automatic cplx_result_t predict_result(input kind_t kind, input logic [127:0] d);
		logic signed [127:0] ar, ai, br, bi, den;
		cplx_result_t r;
		logic sat;
		ar = $signed(d[31:0]);
		ai = $signed(d[63:32]);
		br = $signed(d[95:64]);
		bi = $signed(d[127:96]);
		sat = 1'b0;
		r = '0;
		case (kind)
			KIND_ADD: begin
				r.res_re = clip32(ar + br, sat);
				r.res_im = clip32(ai + bi, sat);
			end
			KIND_SUB: begin
				r.res_re = clip32(ar - br, sat);
				r.res_im = clip32(ai - bi, sat);
			end
			KIND_MUL: begin
				r.res_re = clip32((ar * br - ai * bi) >>> FRAC_BITS, sat);
				r.res_im = clip32((ar * bi + ai * br) >>> FRAC_BITS, sat);
			end
			KIND_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.zero_divide = 1'b1;
				end else begin
					r.res_re = clip32(floor_div(ar * br + ai * bi, den), sat);
					r.res_im = clip32(floor_div(ai * br - ar * bi, den), sat);
				end
			end
			KIND_NEG: begin
				r.res_re = clip32(-ar, sat);
				r.res_im = clip32(-ai, sat);
			end
			KIND_ID: begin
				r.res_re = ar[31:0];
				r.res_im = ai[31:0];
			end
			KIND_MAG: begin
				r.res_re = clip32($signed({64'd0, root_floor(64'(ar * ar + ai * ai))}), sat);
			end
			default: begin
				r.res_re = ar[31:0];
				r.res_im = clip32(-ai, sat);
			end
		endcase
		r.saturated = sat;
		return r;
	endfunction

	assign pending = result_q.size();

	always @(posedge clk) begin
		cplx_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				result_q.push_back(predict_result(kind_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$error("result transaction with no prediction waiting");
					mismatches++;
				end else begin
					want = result_q.pop_front();
					if (m_tdata[31:0] !== want.res_re) begin
						$error("res_re expected %h actual %h", want.res_re, m_tdata[31:0]);
						mismatches++;
					end
					if (m_tdata[63:32] !== want.res_im) begin
						$error("res_im expected %h actual %h", want.res_im, m_tdata[63:32]);
						mismatches++;
					end
					if (m_tuser[0] !== want.zero_divide) begin
						$error("zero_divide expected %b actual %b", want.zero_divide, m_tuser[0]);
						mismatches++;
					end
					if (m_tuser[1] !== want.saturated) begin
						$error("saturated expected %b actual %b", want.saturated, m_tuser[1]);
						mismatches++;
					end
				end
			end
		end
	end

	initial mismatches = 0;

endmodule

// ===== tb/complex_arithmetic_unit_tb.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Drives directed corner operands and random operand pairs of all kinds into
// the complex ALU under several idle and stall patterns; the checker scores.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cau_pkg::*;

	localparam int N_RANDOM = 1330;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;  // a_re, a_im, b_re, b_im
	logic [2:0]   s_tuser;  // kind
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;  // res_re, res_im
	logic [1:0]   m_tuser;  // zero_divide, saturated
	int           mismatches;
	int           pending;
	int           idle_pct;
	int           stall_pct;
	int           sent;

	complex_arithmetic_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	complex_arithmetic_unit_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// hold each transaction until the edge that accepts it; ready is sampled
	// at the falling edge, where it is stable
	task automatic send_op(input kind_t kind, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		logic ready_seen;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {bi, br, ai, ar};
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (!ready_seen);
		sent++;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3, 4, 5: return 32'($signed($urandom_range(2097151)) - 1048576);
			6: return 32'($signed($urandom_range(255)) - 128);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] ar, ai, br, bi;
		kind_t kind;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = KIND_ADD;
		m_tready  = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		sent      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(KIND_ADD,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(KIND_ADD,  32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
		send_op(KIND_SUB,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(KIND_SUB,  32'h0005_8000, 32'h0000_0000, 32'h0001_0000, 32'h0000_4000);
		send_op(KIND_MUL,  32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
		send_op(KIND_MUL,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_op(KIND_MUL,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
		send_op(KIND_MUL,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(KIND_DIV,  32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(KIND_DIV,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(KIND_DIV,  32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
		send_op(KIND_DIV,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
		send_op(KIND_DIV,  32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000, 32'h0000_0000);
		send_op(KIND_DIV,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(KIND_NEG,  32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0);
		send_op(KIND_NEG,  32'h0001_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(KIND_ID,   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(KIND_MAG,  32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(KIND_MAG,  32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
		send_op(KIND_MAG,  32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(KIND_MAG,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(KIND_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(KIND_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int i = 0; i < N_RANDOM; i++) begin
			case ((i * 4) / N_RANDOM)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			kind = kind_t'($urandom_range(7));
			ar = pick_operand();
			ai = pick_operand();
			br = pick_operand();
			bi = pick_operand();
			// keep some divides on a zero denominator
			if (kind == KIND_DIV && $urandom_range(15) == 0) begin
				br = '0;
				bi = '0;
			end
			send_op(kind, ar, ai, br, bi);
		end
		s_tvalid <= 1'b0;
		stall_pct = 0;

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d operations: directed corners, then random operands of all kinds", sent);
		$display("under no idling, sender gaps, receiver stalls and both together.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_queue.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_checker.sv
tb/complex_arithmetic_unit_tb.sv
